[sv/pdt_pkg.sv]
`timescale 1ns / 1ps
// Package for the packed decimal text parser: widths, lane result type, powers of ten.
// No dependencies; imported by every module of the block.
package pdt_pkg;

    localparam int PDT_MAX_CHARS = 9;     // default lane count
    localparam int CHAR_W        = 7;     // ASCII character width
    localparam int TEXT_W        = 64;    // packed text width
    localparam int COUNT_W       = 4;     // character count width
    localparam int SUM_W         = 30;    // unsigned magnitude, up to 999999999
    localparam int VALUE_W       = SUM_W + 1;
    localparam int DIGIT_W       = 4;

    localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 7'h39;

    // what one lane hands to the merge stage
    typedef struct packed {
        logic [SUM_W-1:0] term;     // digit times its place weight
        logic             bad;      // active character is not allowed here
        logic             hyphen;   // character is a hyphen
    } lane_res_t;

    function automatic logic [SUM_W-1:0] pow10(input logic [COUNT_W-1:0] k);
        logic [SUM_W-1:0] w;
        case (k)
            4'd0:    w = SUM_W'(1);
            4'd1:    w = SUM_W'(10);
            4'd2:    w = SUM_W'(100);
            4'd3:    w = SUM_W'(1000);
            4'd4:    w = SUM_W'(10000);
            4'd5:    w = SUM_W'(100000);
            4'd6:    w = SUM_W'(1000000);
            4'd7:    w = SUM_W'(10000000);
            4'd8:    w = SUM_W'(100000000);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

[sv/pdt_lane.sv]
`timescale 1ns / 1ps
// One character lane: classifies a character and weights its digit by its place.
// Depends on pdt_pkg.
module pdt_lane import pdt_pkg::*; #(
    parameter int LANE_IDX = 0
) (
    input  logic [CHAR_W-1:0]  char_in,
    input  logic [COUNT_W-1:0] char_count,
    output lane_res_t          res
);

    logic                 active;
    logic                 is_digit;
    logic                 is_hyphen;
    logic [COUNT_W-1:0]   expo;
    logic [DIGIT_W-1:0]   digit;
    logic [SUM_W-1:0]     weight;

    always_comb begin
        active    = char_count > COUNT_W'(LANE_IDX);
        is_digit  = char_in inside {[CHAR_ZERO:CHAR_NINE]};
        is_hyphen = char_in == CHAR_HYPHEN;
        // place of this character counted from the last valid one
        expo      = char_count - COUNT_W'(LANE_IDX) - COUNT_W'(1);
        digit     = is_digit ? char_in[DIGIT_W-1:0] : '0;
        weight    = active ? pow10(expo) : '0;

        res.term   = {{(SUM_W-DIGIT_W){1'b0}}, digit} * weight;
        res.hyphen = is_hyphen;
        // a leading hyphen is fine unless it is the only character
        res.bad    = active && !is_digit &&
                     !((LANE_IDX == 0) && is_hyphen && (char_count != COUNT_W'(1)));
    end

endmodule

[sv/pdt_merge.sv]
`timescale 1ns / 1ps
// Merge stage: registers lane results, sums them in a registered pairwise tree,
// applies sign and error, and holds the result in an output register. Depends on pdt_pkg.
module pdt_merge import pdt_pkg::*; #(
    parameter int NUM_LANES = PDT_MAX_CHARS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lane_res_t [NUM_LANES-1:0]   lane_res,
    input  logic                        count_bad,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [VALUE_W-1:0]   out_value,
    output logic                        out_error
);

    localparam int LEVELS = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 0;

    logic [SUM_W-1:0]   sum_reg [0:LEVELS][0:NUM_LANES-1];
    logic [LEVELS:0]    vld_reg;
    logic [LEVELS:0]    neg_reg;
    logic [LEVELS:0]    bad_reg;
    logic [LEVELS+1:0]  rdy;
    logic               out_vld_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               err_reg;
    logic               lane_bad;

    // a stage takes a new transfer when empty or when it is moving on
    assign rdy[LEVELS+1] = !out_vld_reg || out_ready;
    genvar k;
    generate
        for (k = 0; k <= LEVELS; k++) begin : g_rdy
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    endgenerate
    assign in_ready = rdy[0];

    always_comb begin
        lane_bad = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_bad = lane_bad | lane_res[i].bad;
        end
    end

    // level 0: lane capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            vld_reg[0] <= in_valid;
        end
        if (rdy[0]) begin
            bad_reg[0] <= count_bad | lane_bad;
            neg_reg[0] <= lane_res[0].hyphen;
            for (int i = 0; i < NUM_LANES; i++) begin
                sum_reg[0][i] <= lane_res[i].term;
            end
        end
    end

    genvar l, j;
    generate
        for (l = 0; l < LEVELS; l++) begin : g_lvl
            localparam int NL  = (NUM_LANES + (1 << l) - 1) >> l;
            localparam int NLN = (NL + 1) >> 1;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[l+1] <= 1'b0;
                end else if (rdy[l+1]) begin
                    vld_reg[l+1] <= vld_reg[l];
                end
                if (rdy[l+1]) begin
                    bad_reg[l+1] <= bad_reg[l];
                    neg_reg[l+1] <= neg_reg[l];
                end
            end

            for (j = 0; j < NLN; j++) begin : g_node
                if (2 * j + 1 < NL) begin : g_pair
                    always_ff @(posedge aclk) begin
                        if (rdy[l+1]) begin
                            sum_reg[l+1][j] <= sum_reg[l][2*j] + sum_reg[l][2*j+1];
                        end
                    end
                end else begin : g_pass
                    always_ff @(posedge aclk) begin
                        if (rdy[l+1]) begin
                            sum_reg[l+1][j] <= sum_reg[l][2*j];
                        end
                    end
                end
            end
        end
    endgenerate

    // sign and error; error forces zero
    always_comb begin
        if (bad_reg[LEVELS]) begin
            value_next = '0;
        end else if (neg_reg[LEVELS]) begin
            value_next = VALUE_W'(0) - {1'b0, sum_reg[LEVELS][0]};
        end else begin
            value_next = {1'b0, sum_reg[LEVELS][0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (rdy[LEVELS+1]) begin
            out_vld_reg <= vld_reg[LEVELS];
        end
        if (rdy[LEVELS+1]) begin
            value_reg <= value_next;
            err_reg   <= bad_reg[LEVELS];
        end
    end

    assign out_valid = out_vld_reg;
    assign out_value = $signed(value_reg);
    assign out_error = err_reg;

    // an error result always carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_error |-> out_value == '0)
        else $error("error result with nonzero value");

    // input stalls only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (&vld_reg) && out_valid && !out_ready)
        else $error("input stalled with a free stage");

    // a negative result is never an error result
    a_neg_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_value[VALUE_W-1] |-> !out_error)
        else $error("negative value on error result");

endmodule

[sv/packed_decimal_text_to_integer.sv]
`timescale 1ns / 1ps
// Top level of the packed decimal text parser: character lanes and merge pipeline.
// Depends on pdt_pkg, pdt_lane and pdt_merge.
//
//  Channel | Ports                          | Contents
//  --------+--------------------------------+-----------------------------------------
//  input   | s_tvalid s_tready s_tdata[71:0] | packed_text, char_count
//  result  | m_tvalid m_tready m_tdata[31:0] | number_value; m_tuser = parse_error
//
// Throughput: one transfer per cycle on each side, back to back, while m_tready stays high.
// Pipeline: lane capture register, the levels of the registered adder tree, and the
//   output register.
// Reset (aresetn low, synchronous) empties every stage; no state survives an item.
// Stalls: each stage moves into an empty slot, so input keeps flowing while a
//   finished result waits, until all stages are full.
module packed_decimal_text_to_integer import pdt_pkg::*; #(
    parameter int MAX_CHARS = PDT_MAX_CHARS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // [63:0] packed_text, [67:64] char_count, [71:68] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [30:0] number_value (signed), [31] zero
    output logic [0:0]  m_tuser     // [0] parse_error
);

    logic [TEXT_W-1:0]             packed_text;
    logic [COUNT_W-1:0]            char_count;
    logic                          count_bad;
    lane_res_t [MAX_CHARS-1:0]     lane_res;
    logic signed [VALUE_W-1:0]     number_value;
    logic                          parse_error;

    assign packed_text = s_tdata[TEXT_W-1:0];
    assign char_count  = s_tdata[TEXT_W +: COUNT_W];

    // empty text or more characters than lanes
    assign count_bad = (char_count == '0) || (char_count > COUNT_W'(MAX_CHARS));

    // lane p sees character p; the first character sits in the top bits
    genvar p;
    generate
        for (p = 0; p < MAX_CHARS; p++) begin : g_lane
            pdt_lane #(
                .LANE_IDX (p)
            ) u_lane (
                .char_in    (packed_text[TEXT_W-1-CHAR_W*p -: CHAR_W]),
                .char_count (char_count),
                .res        (lane_res[p])
            );
        end
    endgenerate

    pdt_merge #(
        .NUM_LANES (MAX_CHARS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .lane_res  (lane_res),
        .count_bad (count_bad),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (number_value),
        .out_error (parse_error)
    );

    assign m_tdata = {1'b0, number_value};
    assign m_tuser = parse_error;

endmodule
